// ===== hdl/awb_pkg.sv =====
// ----------------------------------------------------------------------------
// awb_pkg: shared constants, types and helpers for the affine warp unit
// Sizes of the frame store, fixed-point layout, register indexes and the
// struct that passes between the front and back parts.
// ----------------------------------------------------------------------------
package awb_pkg;

   localparam int SrcMaxWidth  = 256;
   localparam int SrcMaxHeight = 256;
   localparam int Channels     = 4;
   localparam int FracBits     = 8;

   localparam int XW     = $clog2(SrcMaxWidth);
   localparam int YW     = $clog2(SrcMaxHeight);
   localparam int AddrW  = XW + YW;
   localparam int Depth  = SrcMaxWidth * SrcMaxHeight;
   localparam int WgtW   = 2 * FracBits + 1;
   localparam int AccW   = WgtW + 10;
   // integer part of a source position: 48-bit Q32.16 leaves 32 bits, clipped
   localparam int IpW    = 20;

   localparam int CoordW = 12;
   localparam int PixW   = 32;
   localparam int CsrIdxW = 3;
   localparam int CsrW    = 33;

   typedef enum logic [CsrIdxW-1:0] {
      REG_INV_XX = 3'd0, REG_INV_XY = 3'd1, REG_INV_XT = 3'd2,
      REG_INV_YX = 3'd3, REG_INV_YY = 3'd4, REG_INV_YT = 3'd5,
      REG_SOURCE_SIZE = 3'd6, REG_BORDER_CONTROL = 3'd7
   } csr_idx_type;

   typedef enum logic {OP_WRITE = 1'b0, OP_READ = 1'b1} op_type;

   // one classified item in the queue between front and back
   typedef struct packed {
      logic              is_read;
      logic [AddrW-1:0]  waddr;
      logic              wen;
      logic [PixW-1:0]   wdata;
      logic [AddrW-1:0]  addr00;
      logic [AddrW-1:0]  addr10;
      logic [AddrW-1:0]  addr01;
      logic [AddrW-1:0]  addr11;
      logic [3:0]        use_border;
      logic              zero_fill;
      logic [FracBits-1:0] ax;
      logic [FracBits-1:0] ay;
   } job_type;

endpackage

// ===== hdl/affine_warp_bilinear_unit.sv =====
// ----------------------------------------------------------------------------
// affine_warp_bilinear_unit: affine warp with bilinear interpolation
// Source pixels are written into a frame store; destination requests are
// mapped through the inverse matrix and blended from a 2x2 neighborhood.
// ----------------------------------------------------------------------------
//  channel  ports                                        direction
//  req      req_valid/stall, op, coord_x/y, pixel_in     in
//  rsp      rsp_valid/stall, pixel_out                   out
//  csr      csr_write, csr_index, csr_data               in
//
// One word per cycle sustained while rsp is not stalled; a read's word passes
// 4 front stages, the queue and 4 back stages incl. the store read.
// Writes give no word. Reset sets the matrix registers to identity and the
// size and border registers to zero; the store is not cleared. A stall on rsp
// backs up the back part, then the queue, then req_stall.
module affine_warp_bilinear_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [awb_pkg::CoordW-1:0]   req_coord_x,
   input  logic [awb_pkg::CoordW-1:0]   req_coord_y,
   input  logic [awb_pkg::PixW-1:0]     req_pixel_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [awb_pkg::PixW-1:0]     rsp_pixel_out,
   input  logic                         csr_write,
   input  logic [awb_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [awb_pkg::CsrW-1:0]     csr_data
);
   import awb_pkg::*;

   logic signed [31:0] inv_xx_ff, inv_xy_ff, inv_xt_ff;
   logic signed [31:0] inv_yx_ff, inv_yy_ff, inv_yt_ff;
   logic [31:0] size_ff;
   logic [32:0] border_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_xx_ff <= 32'sd65536; inv_xy_ff <= '0; inv_xt_ff <= '0;
         inv_yx_ff <= '0; inv_yy_ff <= 32'sd65536; inv_yt_ff <= '0;
         size_ff <= '0; border_ff <= '0;
      end else if (csr_write) begin
         case (csr_idx_type'(csr_index))
            REG_INV_XX: inv_xx_ff <= csr_data[31:0];
            REG_INV_XY: inv_xy_ff <= csr_data[31:0];
            REG_INV_XT: inv_xt_ff <= csr_data[31:0];
            REG_INV_YX: inv_yx_ff <= csr_data[31:0];
            REG_INV_YY: inv_yy_ff <= csr_data[31:0];
            REG_INV_YT: inv_yt_ff <= csr_data[31:0];
            REG_SOURCE_SIZE: size_ff <= csr_data[31:0];
            REG_BORDER_CONTROL: border_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic f_valid, f_ready, b_valid, b_ready;
   job_type f_job, b_job;

   awb_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_op, .req_coord_x,
      .req_coord_y, .req_pixel_in,
      .inv_xx(inv_xx_ff), .inv_xy(inv_xy_ff), .inv_xt(inv_xt_ff),
      .inv_yx(inv_yx_ff), .inv_yy(inv_yy_ff), .inv_yt(inv_yt_ff),
      .source_size(size_ff), .border_const(border_ff[32]),
      .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
   );

   awb_queue u_queue (
      .clock, .reset, .push_valid(f_valid), .push_ready(f_ready),
      .push_data(f_job), .pop_valid(b_valid), .pop_ready(b_ready),
      .pop_data(b_job)
   );

   awb_back u_back (
      .clock, .reset, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
      .border_bytes(border_ff[31:0]), .rsp_valid, .rsp_stall, .rsp_pixel_out
   );

endmodule

// ===== hdl/awb_front.sv =====
// ----------------------------------------------------------------------------
// awb_front: coordinate mapping and neighbor classification
// Four-stage pipeline: products, sums, split and range checks, addresses.
// Advances when its last stage is empty or drains into the queue.
// ----------------------------------------------------------------------------
module awb_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_op,
   input  logic [awb_pkg::CoordW-1:0]  req_coord_x,
   input  logic [awb_pkg::CoordW-1:0]  req_coord_y,
   input  logic [awb_pkg::PixW-1:0]    req_pixel_in,
   input  logic signed [31:0]          inv_xx,
   input  logic signed [31:0]          inv_xy,
   input  logic signed [31:0]          inv_xt,
   input  logic signed [31:0]          inv_yx,
   input  logic signed [31:0]          inv_yy,
   input  logic signed [31:0]          inv_yt,
   input  logic [31:0]                 source_size,
   input  logic                        border_const,
   output logic                        job_valid,
   output awb_pkg::job_type            job,
   input  logic                        job_ready
);
   import awb_pkg::*;

   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   // stage 1 payload
   logic op1_ff;
   logic [CoordW-1:0] cx1_ff, cy1_ff;
   logic [PixW-1:0] pix1_ff;
   logic signed [44:0] pxx_ff, pxy_ff, pyx_ff, pyy_ff;
   // stage 2 payload
   logic op2_ff;
   logic [CoordW-1:0] cx2_ff, cy2_ff;
   logic [PixW-1:0] pix2_ff;
   logic signed [47:0] fx_ff, fy_ff;
   // stage 3 payload
   logic op3_ff;
   logic [CoordW-1:0] cx3_ff, cy3_ff;
   logic [PixW-1:0] pix3_ff;
   logic signed [IpW-1:0] x0_ff, y0_ff;
   logic [FracBits-1:0] ax3_ff, ay3_ff;
   logic [16:0] w_ff, h_ff;
   // stage 4 output
   job_type job_ff, job_in;

   assign adv = !v4_ff || job_ready;
   assign req_stall = !adv;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
      end
   end

   // stage 1: one multiplier per term
   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff  <= req_op; cx1_ff <= req_coord_x; cy1_ff <= req_coord_y;
         pix1_ff <= req_pixel_in;
         pxx_ff <= inv_xx * $signed({1'b0, req_coord_x});
         pxy_ff <= inv_xy * $signed({1'b0, req_coord_y});
         pyx_ff <= inv_yx * $signed({1'b0, req_coord_x});
         pyy_ff <= inv_yy * $signed({1'b0, req_coord_y});
      end
   end

   // stage 2: sums
   always_ff @(posedge clock) begin
      if (adv) begin
         op2_ff <= op1_ff; cx2_ff <= cx1_ff; cy2_ff <= cy1_ff; pix2_ff <= pix1_ff;
         fx_ff <= 48'(pxx_ff) + 48'(pxy_ff) + 48'(inv_xt);
         fy_ff <= 48'(pyx_ff) + 48'(pyy_ff) + 48'(inv_yt);
      end
   end

   // stage 3: floor split, clipped integer part, saturated size
   logic signed [31:0] ipx_full, ipy_full;
   logic signed [IpW-1:0] ipx_c, ipy_c;
   logic [15:0] sw, sh;
   assign ipx_full = fx_ff[47:16];
   assign ipy_full = fy_ff[47:16];
   // clip keeps out-of-range positions out of range on the same side
   always_comb begin
      if (ipx_full > 32'sd100000) ipx_c = IpW'(100000);
      else if (ipx_full < -32'sd100000) ipx_c = -IpW'(100000);
      else ipx_c = ipx_full[IpW-1:0];
      if (ipy_full > 32'sd100000) ipy_c = IpW'(100000);
      else if (ipy_full < -32'sd100000) ipy_c = -IpW'(100000);
      else ipy_c = ipy_full[IpW-1:0];
   end
   assign sw = source_size[15:0];
   assign sh = source_size[31:16];

   always_ff @(posedge clock) begin
      if (adv) begin
         op3_ff <= op2_ff; cx3_ff <= cx2_ff; cy3_ff <= cy2_ff; pix3_ff <= pix2_ff;
         x0_ff <= ipx_c; y0_ff <= ipy_c;
         ax3_ff <= fx_ff[15 -: FracBits];
         ay3_ff <= fy_ff[15 -: FracBits];
         w_ff <= (sw > 16'(SrcMaxWidth))  ? 17'(SrcMaxWidth)  : {1'b0, sw};
         h_ff <= (sh > 16'(SrcMaxHeight)) ? 17'(SrcMaxHeight) : {1'b0, sh};
      end
   end

   // stage 4: neighbor classification and addresses
   logic signed [IpW-1:0] xs [2];
   logic signed [IpW-1:0] ys [2];
   logic [XW-1:0] xc [2];
   logic [YW-1:0] yc [2];
   logic xin [2];
   logic yin [2];
   logic empty;
   always_comb begin
      empty = (w_ff == 17'd0) || (h_ff == 17'd0);
      xs[0] = x0_ff; xs[1] = x0_ff + IpW'(1);
      ys[0] = y0_ff; ys[1] = y0_ff + IpW'(1);
      for (int i = 0; i < 2; i++) begin
         xin[i] = (xs[i] >= 0) && (xs[i] < $signed({3'b0, w_ff}));
         yin[i] = (ys[i] >= 0) && (ys[i] < $signed({3'b0, h_ff}));
         if (xs[i] < 0) xc[i] = '0;
         else if (!xin[i]) xc[i] = XW'(w_ff - 17'd1);
         else xc[i] = xs[i][XW-1:0];
         if (ys[i] < 0) yc[i] = '0;
         else if (!yin[i]) yc[i] = YW'(h_ff - 17'd1);
         else yc[i] = ys[i][YW-1:0];
      end
      job_in = '0;
      job_in.is_read = (op3_ff == OP_READ);
      job_in.wdata   = pix3_ff;
      job_in.waddr   = {cy3_ff[YW-1:0], cx3_ff[XW-1:0]};
      job_in.wen     = (op3_ff == OP_WRITE) && (32'(cx3_ff) < SrcMaxWidth)
                       && (32'(cy3_ff) < SrcMaxHeight);
      job_in.addr00  = {yc[0], xc[0]};
      job_in.addr10  = {yc[0], xc[1]};
      job_in.addr01  = {yc[1], xc[0]};
      job_in.addr11  = {yc[1], xc[1]};
      // an empty image has no edge pixel: constant mode gives the border,
      // replicate mode gives zero
      job_in.use_border[0] = (!(xin[0] && yin[0])) && (border_const || empty);
      job_in.use_border[1] = (!(xin[1] && yin[0])) && (border_const || empty);
      job_in.use_border[2] = (!(xin[0] && yin[1])) && (border_const || empty);
      job_in.use_border[3] = (!(xin[1] && yin[1])) && (border_const || empty);
      job_in.zero_fill = empty && !border_const;
      job_in.ax = ax3_ff;
      job_in.ay = ay3_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) job_ff <= job_in;
   end

   assign job_valid = v4_ff;
   assign job = job_ff;

endmodule

// ===== hdl/awb_queue.sv =====
// ----------------------------------------------------------------------------
// awb_queue: short queue between front and back
// Four entries of classified words; full stalls the front, empty idles the back.
// ----------------------------------------------------------------------------
module awb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  awb_pkg::job_type  push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output awb_pkg::job_type  pop_data
);
   import awb_pkg::*;

   job_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic push, pop;

   assign push_ready = (cnt_ff != 3'd4);
   assign pop_valid  = (cnt_ff != 3'd0);
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;
   assign pop_data = mem_ff[rp_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop)  rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

endmodule

// ===== hdl/awb_back.sv =====
// ----------------------------------------------------------------------------
// awb_back: frame store, bilinear blend and output register
// Four store copies give four reads a cycle; a write updates all of them.
// Stages: store read, weights and border select, products, sum and round.
// ----------------------------------------------------------------------------
module awb_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     job_valid,
   output logic                     job_ready,
   input  awb_pkg::job_type         job,
   input  logic [31:0]              border_bytes,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [awb_pkg::PixW-1:0] rsp_pixel_out
);
   import awb_pkg::*;

   logic adv;
   logic [PixW-1:0] mem0 [Depth];
   logic [PixW-1:0] mem1 [Depth];
   logic [PixW-1:0] mem2 [Depth];
   logic [PixW-1:0] mem3 [Depth];
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic [PixW-1:0] p_ff [4];
   logic [3:0] ub1_ff;
   logic zf1_ff;
   logic [FracBits-1:0] ax1_ff, ay1_ff;
   logic [7:0] b2_ff [4][Channels];
   logic [WgtW-1:0] w2_ff [4];
   logic [AccW-1:0] m3_ff [4][Channels];
   logic [PixW-1:0] out_ff, out_in;

   assign adv = !v4_ff || !rsp_stall;
   assign job_ready = adv;

   // valid chain (reads only)
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= job_valid && job.is_read;
         v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
      end
   end

   // store write and read
   always_ff @(posedge clock) begin
      if (adv && job_valid && job.wen) begin
         mem0[job.waddr] <= job.wdata; mem1[job.waddr] <= job.wdata;
         mem2[job.waddr] <= job.wdata; mem3[job.waddr] <= job.wdata;
      end
      if (adv) begin
         p_ff[0] <= mem0[job.addr00]; p_ff[1] <= mem1[job.addr10];
         p_ff[2] <= mem2[job.addr01]; p_ff[3] <= mem3[job.addr11];
         ub1_ff <= job.use_border; zf1_ff <= job.zero_fill;
         ax1_ff <= job.ax; ay1_ff <= job.ay;
      end
   end

   // weights and border select
   logic [FracBits:0] one, nax, nay;
   assign one = (FracBits+1)'(1) << FracBits;
   assign nax = one - {1'b0, ax1_ff};
   assign nay = one - {1'b0, ay1_ff};
   always_ff @(posedge clock) begin
      if (adv) begin
         w2_ff[0] <= WgtW'(nax * nay);
         w2_ff[1] <= WgtW'({1'b0, ax1_ff} * nay);
         w2_ff[2] <= WgtW'(nax * {1'b0, ay1_ff});
         w2_ff[3] <= WgtW'({1'b0, ax1_ff} * {1'b0, ay1_ff});
         for (int n = 0; n < 4; n++)
            for (int k = 0; k < Channels; k++)
               b2_ff[n][k] <= ub1_ff[n] ? (zf1_ff ? 8'h00 : border_bytes[8*k +: 8])
                                        : p_ff[n][8*k +: 8];
      end
   end

   // per-channel products
   always_ff @(posedge clock) begin
      if (adv)
         for (int n = 0; n < 4; n++)
            for (int k = 0; k < Channels; k++)
               m3_ff[n][k] <= AccW'(b2_ff[n][k] * w2_ff[n]);
   end

   // sum, round and clamp
   logic [AccW-1:0] s;
   always_comb begin
      out_in = '0;
      s = '0;
      for (int k = 0; k < Channels; k++) begin
         s = m3_ff[0][k] + m3_ff[1][k] + m3_ff[2][k] + m3_ff[3][k]
             + (AccW'(1) << (2*FracBits-1));
         s = s >> (2*FracBits);
         out_in[8*k +: 8] = (s > AccW'(255)) ? 8'hff : s[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) out_ff <= out_in;
   end

   assign rsp_valid = v4_ff;
   assign rsp_pixel_out = out_ff;

endmodule
